// File: src/modular_exponentiation_assert.svh
// assertion macros used by the checker file src/mx_checker.sv
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MX_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MX_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// File: src/mx_pkg.sv
// shared constants for the modular exponentiation block
`default_nettype none
package mx_pkg;
   localparam int DATA_W        = 32;
   localparam int EXP_BITS_DEF  = 32;
   localparam int MOD_BITS_DEF  = 32;
   localparam int CHAIN_LEN     = 32;
   localparam int CNT_W         = $clog2(CHAIN_LEN + 1);
   localparam int ADDR_W        = 3;
   localparam logic [DATA_W-1:0] BASE_RESET = 32'd2;
   localparam logic [DATA_W-1:0] MOD_RESET  = 32'd1000000007;
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_MOD  = 1'b1;
endpackage
`default_nettype wire

// File: src/modular_exponentiation.sv
// modular exponentiation top level: csr port, sequencer and two multiply chains
// a modulus of 0 skips the multiply passes: the item goes from idle straight to the done state
// one item at a time: a new item is taken only in the idle state, and the done state waits on a stalled result
// each exponent bit costs one pass through a 32-cell chain followed by a capture of the products,
// a new item is taken while the previous result still waits for transfer
// reset is synchronous: base 2, modulus 1000000007, no item in flight
`default_nettype none
module modular_exponentiation import mx_pkg::*; #(
   parameter int EXP_BITS = EXP_BITS_DEF,
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DATA_W-1:0] req_exponent,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DATA_W-1:0] rsp_power_result,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);
   localparam int BIT_W = $clog2(EXP_BITS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RUN, ST_DONE} state_type;

   state_type           state_ff, state_in;
   logic [DATA_W-1:0]   base_ff, base_in;
   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [MOD_BITS-1:0] m_ff, m_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [BIT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]    cyc_cnt_ff, cyc_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                 csr_write;
   logic [MOD_BITS-1:0]  one_mod;
   logic [MOD_BITS-1:0]  mul_a_out, mul_b_out;
   logic [MOD_BITS-1:0]  lane_b_a;
   logic [CHAIN_LEN-1:0] lane_b_y;
   logic                 pass_done;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign one_mod   = MOD_BITS'(m_ff != MOD_BITS'(1));
   assign lane_b_a  = (state_ff == ST_PREP) ? one_mod : b_ff;
   assign lane_b_y  = (state_ff == ST_PREP) ? base_ff : CHAIN_LEN'(b_ff);
   assign pass_done = (cyc_cnt_ff == CNT_W'(CHAIN_LEN));

   // lane a: acc * b, lane b: b * b (or base reduction in the prep pass)
   mx_chain #(.MOD_BITS(MOD_BITS)) u_chain_a (
      .clock   (clock),
      .m       (m_ff),
      .a       (acc_ff),
      .y       (CHAIN_LEN'(b_ff)),
      .product (mul_a_out)
   );

   mx_chain #(.MOD_BITS(MOD_BITS)) u_chain_b (
      .clock   (clock),
      .m       (m_ff),
      .a       (lane_b_a),
      .y       (lane_b_y),
      .product (mul_b_out)
   );

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      modulus_in   = modulus_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      cyc_cnt_in   = cyc_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_BASE: base_in    = csr_pwdata;
            REG_MOD:  modulus_in = MOD_BITS'(csr_pwdata);
            default:  ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in       = modulus_ff;
               exp_in     = EXP_BITS'(req_exponent);
               acc_in     = MOD_BITS'(modulus_ff != MOD_BITS'(1));
               bit_cnt_in = '0;
               cyc_cnt_in = '0;
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cyc_cnt_in = cyc_cnt_ff + CNT_W'(1);
            if (pass_done) begin
               b_in       = mul_b_out;
               cyc_cnt_in = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            cyc_cnt_in = cyc_cnt_ff + CNT_W'(1);
            if (pass_done) begin
               if (exp_ff[0]) begin
                  acc_in = mul_a_out;
               end
               b_in       = mul_b_out;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff + BIT_W'(1);
               cyc_cnt_in = '0;
               if (bit_cnt_ff == BIT_W'(EXP_BITS - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_W'(acc_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
         modulus_ff   <= MOD_BITS'(MOD_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         modulus_ff   <= modulus_in;
      end
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      b_ff        <= b_in;
      exp_ff      <= exp_in;
      bit_cnt_ff  <= bit_cnt_in;
      cyc_cnt_ff  <= cyc_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr[2] == REG_MOD) ? DATA_W'(modulus_ff) : base_ff;
endmodule
`default_nettype wire

// File: src/mx_cell.sv
// one step of interleaved modular multiplication: r = 2r + a*bit mod m
`default_nettype none
module mx_cell #(
   parameter int MOD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic [MOD_BITS-1:0] m,
   input  wire logic [MOD_BITS-1:0] a,
   input  wire logic                y_bit,
   input  wire logic [MOD_BITS-1:0] r_prev,
   output logic      [MOD_BITS-1:0] r_ff
);
   logic [MOD_BITS:0]   dbl;
   logic [MOD_BITS-1:0] dbl_red;
   logic [MOD_BITS:0]   sum;
   logic [MOD_BITS-1:0] r_in;

   always_comb begin
      dbl     = {r_prev, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? MOD_BITS'(dbl - {1'b0, m}) : dbl[MOD_BITS-1:0];
      sum     = {1'b0, dbl_red} + (y_bit ? {1'b0, a} : '0);
      r_in    = (sum >= {1'b0, m}) ? MOD_BITS'(sum - {1'b0, m}) : sum[MOD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end
endmodule
`default_nettype wire

// File: src/mx_chain.sv
// row of multiply cells, multiplier bits fed msb first along the row
`default_nettype none
module mx_chain import mx_pkg::*; #(
   parameter int MOD_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic [MOD_BITS-1:0]  m,
   input  wire logic [MOD_BITS-1:0]  a,
   input  wire logic [CHAIN_LEN-1:0] y,
   output logic      [MOD_BITS-1:0]  product
);
   logic [MOD_BITS-1:0] r [CHAIN_LEN];

   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      mx_cell #(.MOD_BITS(MOD_BITS)) u_cell (
         .clock  (clock),
         .m      (m),
         .a      (a),
         .y_bit  (y[CHAIN_LEN-1-i]),
         .r_prev ((i == 0) ? '0 : r[(i == 0) ? 0 : i-1]),
         .r_ff   (r[i])
      );
   end

   assign product = r[CHAIN_LEN-1];
endmodule
`default_nettype wire

// File: src/mx_checker.sv
// port-level checks for the modular exponentiation block
`default_nettype none
`include "modular_exponentiation_assert.svh"
module mx_checker import mx_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_power_result,
   input wire logic              csr_pready
);
   `MX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_power_result))
   `MX_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready)
   `MX_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `MX_ASSERT_NOW(a_no_instant_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready))
endmodule

bind modular_exponentiation mx_checker u_mx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_power_result (rsp_power_result),
   .csr_pready       (csr_pready)
);
`default_nettype wire

// File: tb/modular_exponentiation_checker.sv
// checker for the modular exponentiation block: watches both channels and the csr port
`timescale 1ns / 100ps
`default_nettype none
module modular_exponentiation_checker import mx_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [DATA_W-1:0] req_exponent,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [DATA_W-1:0] rsp_power_result,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic              csr_pready,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count
);
   logic [DATA_W-1:0] cur_base;
   logic [DATA_W-1:0] cur_modulus;
   logic [DATA_W-1:0] expected_powers[$];

   function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] bv,
                                                        input logic [DATA_W-1:0] mv,
                                                        input logic [DATA_W-1:0] ex);
      logic [63:0] acc;
      logic [63:0] sq;
      if (mv == 0) return '0;
      acc = 64'd1 % mv;
      sq  = {32'd0, bv} % mv;
      for (int i = 0; i < EXP_BITS_DEF; i++) begin
         if (ex[i]) acc = (acc * sq) % mv;
         sq = (sq * sq) % mv;
      end
      return acc[DATA_W-1:0];
   endfunction

   assign pending_count = expected_powers.size();

   always @(posedge clock) begin
      if (reset) begin
         cur_base    <= BASE_RESET;
         cur_modulus <= MOD_RESET;
         expected_powers.delete();
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_BASE) cur_base <= csr_pwdata;
            else if (csr_paddr[2] == REG_MOD) cur_modulus <= csr_pwdata;
         end
         if (req_valid && req_ready)
            expected_powers = {expected_powers,
                               predict_power(cur_base, cur_modulus, req_exponent)};
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_powers.size() == 0) begin
               $error("power_result transfer with nothing expected: actual %0d",
                      rsp_power_result);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_power_result !== expected_powers[0]) begin
                  $error("power_result mismatch: expected %0d actual %0d",
                         expected_powers[0], rsp_power_result);
                  fail_count <= fail_count + 1;
               end
               void'(expected_powers.pop_front());
            end
         end
      end
   end
endmodule
`default_nettype wire

// File: tb/tb_modular_exponentiation.sv
// testbench top for the modular exponentiation block: stimulus, csr phases and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_modular_exponentiation;
   import mx_pkg::*;

   localparam int ITEM_LATENCY = 1 + 33 * (EXP_BITS_DEF + 1) + 1;
   localparam longint CYCLE_LIMIT = 4_000_000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [DATA_W-1:0] req_exponent = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [DATA_W-1:0] rsp_power_result;
   logic              csr_psel = 0;
   logic              csr_penable = 0;
   logic              csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;
   int                fail_count, pending_count, result_count;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   longint            cycle_count = 0;
   int                items_sent = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   modular_exponentiation u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_exponent,
      .rsp_valid, .rsp_ready, .rsp_power_result,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   modular_exponentiation_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_exponent,
      .rsp_valid, .rsp_ready, .rsp_power_result,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending_count, .result_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic csr_write(input logic reg_sel, input logic [DATA_W-1:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   // valid stays up after a transfer until the next call or drain_results drops or reloads it
   task automatic send_exponent(input logic [DATA_W-1:0] ex);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid    <= 1;
      req_exponent <= ex;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (ITEM_LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_exponent();
      case ($urandom_range(4))
         0: return DATA_W'($urandom_range(15));
         1: return 32'hFFFF_FFFF >> $urandom_range(31);
         2: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_modulus();
      case ($urandom_range(5))
         0: return DATA_W'($urandom_range(1, 16));
         1: return 32'hFFFF_FFFF;
         2: return 32'd1000000007;
         3: return 32'hFFFF_FFFF >> $urandom_range(1, 31);
         default: return $urandom | 32'd1;
      endcase
   endfunction

   initial begin
      logic [DATA_W-1:0] directed[$];
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000006};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset values first, then extremes of base and modulus
      foreach (directed[i]) send_exponent(directed[i]);
      drain_results();
      csr_write(REG_MOD, 32'd1);
      csr_write(REG_BASE, 32'hFFFF_FFFF);
      foreach (directed[i]) send_exponent(directed[i]);
      drain_results();
      csr_write(REG_MOD, 32'hFFFF_FFFF);
      csr_write(REG_BASE, 32'd0);
      send_exponent(32'd0);
      send_exponent(32'd5);
      drain_results();
      csr_write(REG_MOD, 32'd0);
      send_exponent(32'd7);
      send_exponent(32'd0);
      drain_results();
      csr_write(REG_BASE, 32'hFFFF_FFFE);
      csr_write(REG_MOD, 32'hFFFF_FFFF);
      send_exponent(32'hFFFF_FFFF);
      send_exponent(32'd2);
      drain_results();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 48 : 0;
         recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 38 : 0;
         for (int blk = 0; blk < 8; blk++) begin
            drain_results();
            csr_write(REG_MOD, random_modulus());
            csr_write(REG_BASE, ($urandom_range(3) == 0) ? DATA_W'($urandom_range(3))
                                                         : $urandom);
            repeat (25) send_exponent(random_exponent());
         end
      end
      drain_results();

      $display("run covered %0d exponents with %0d results checked,", items_sent,
               result_count);
      $display("over 29 base/modulus settings and three stall patterns");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
